// ----- sv/fnvdd_pkg.sv -----
// Package for the FNV-1a de-duplication counter: table geometry, hash constants,
// controller state type, command and status structs and saturating helpers.
// Depends on nothing; every other file of the block imports it.
package fnvdd_pkg;

  // Number of slots in the hash set. Must be a power of two (16 to 65536),
  // because the home slot is taken from the low hash bits.
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);

  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] Max32    = 32'hFFFF_FFFF;
  localparam logic [47:0] Max48    = 48'hFFFF_FFFF_FFFF;

  // One table word: valid bit on top of the stored hash.
  localparam int unsigned SlotW = 33;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } fnvdd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // an input transaction completes this cycle
    logic clear_step;  // write an empty word at the clearing index
    logic mem_read;    // read the slot at the probe index
    logic insert;      // store the finished hash at the probe index
    logic mark_dup;    // probe found an equal hash
    logic mark_full;   // probe visited every slot without success
    logic advance;     // move to the next slot
    logic emit;        // update totals and load the output register
  } fnvdd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // clearing index is on the last slot
    logic slot_used;   // slot just read holds a hash
    logic slot_match;  // that hash equals the finished hash
    logic probe_last;  // the slot just read was the last one left to visit
    logic out_free;    // output register can take a new result this cycle
  } fnvdd_stat_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == Max32) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add48 = s[48] ? Max48 : s[47:0];
  endfunction

endpackage

// ----- sv/fnv1a_dedup_counter.sv -----
// Top level of the FNV-1a de-duplication counter: joins the controller and the
// datapath. Depends on fnvdd_pkg, fnvdd_ctrl and fnvdd_dp.
//
// This block takes the bytes of a stream of files, one byte per input
// transaction, with last_byte_i marking the final byte of each file. It hashes
// every file with 32-bit FNV-1a over the unsigned byte values and counts its
// length. When the last byte arrives, the hash is looked up in a linear-probed
// set of 1024 slots (TableDepth in the package): a miss stores the hash, a hit
// marks the file as a duplicate, and a miss with no free slot sets table_full_o
// and still counts the file as unique. Each file yields exactly one output
// transaction carrying its hash, the two flags and saturating running totals.
// Timing: ordinary bytes are taken at one per cycle. After the last byte of a
// file the input stalls while the probe visits slots, each visit being one
// registered read of the table memory and one compare, and while the result
// waits for a previous result to be taken from the output register. After
// reset, a clearing pass writes every slot of the table memory empty, one slot
// per cycle, and in_ready_o first rises once that pass has finished. A
// finished result sits in the output register while bytes of the next file
// keep flowing in.
module fnv1a_dedup_counter import fnvdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] file_hash_o,
  output logic        is_duplicate_o,
  output logic        table_full_o,
  output logic [31:0] files_seen_o,
  output logic [31:0] duplicates_seen_o,
  output logic [31:0] unique_seen_o,
  output logic [47:0] bytes_total_o,
  output logic [47:0] bytes_unique_o
);

  fnvdd_cmd_t  cmd;
  fnvdd_stat_t stat;

  // The controller sequences the clearing pass, byte intake and the probe.
  fnvdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // The datapath holds the hash, the table memory, the totals and the results.
  fnvdd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .byte_value_i      (byte_value_i),
    .last_byte_i       (last_byte_i),
    .out_ready_i       (out_ready_i),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .file_hash_o       (file_hash_o),
    .is_duplicate_o    (is_duplicate_o),
    .table_full_o      (table_full_o),
    .files_seen_o      (files_seen_o),
    .duplicates_seen_o (duplicates_seen_o),
    .unique_seen_o     (unique_seen_o),
    .bytes_total_o     (bytes_total_o),
    .bytes_unique_o    (bytes_unique_o)
  );

  // A hash is only ever written into a slot that was read as empty.
  a_insert_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> !stat.slot_used)
    else $error("hash inserted into an occupied slot");

  // A new result is never loaded over one that has not been taken.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  // A file is either a duplicate or failed to fit, never both.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_duplicate_o && table_full_o))
    else $error("duplicate and table-full flags both set");

  // Until saturation every finished file is counted as duplicate or unique.
  a_count_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (files_seen_o != Max32) |->
      ({1'b0, files_seen_o} == ({1'b0, duplicates_seen_o} + {1'b0, unique_seen_o})))
    else $error("file count does not match duplicate plus unique counts");

  // Unique bytes are a part of all bytes.
  a_bytes_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_unique_o <= bytes_total_o)
    else $error("unique byte sum exceeds total byte sum");

endmodule

// ----- sv/fnvdd_ctrl.sv -----
// Controller of the FNV-1a de-duplication counter: clearing pass, byte intake
// and the slot-by-slot probe of the hash set. Depends on fnvdd_pkg.
module fnvdd_ctrl import fnvdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        last_byte_i,
  input  fnvdd_stat_t stat_i,
  output logic        in_ready_o,
  output fnvdd_cmd_t  cmd_o
);

  fnvdd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && last_byte_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat_i.slot_used || stat_i.slot_match || stat_i.probe_last) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_READ: begin
        cmd_o.mem_read = 1'b1;
      end
      ST_CHECK: begin
        priority if (!stat_i.slot_used) begin
          cmd_o.insert = 1'b1;
        end else if (stat_i.slot_match) begin
          cmd_o.mark_dup = 1'b1;
        end else if (stat_i.probe_last) begin
          cmd_o.mark_full = 1'b1;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/fnvdd_dp.sv -----
// Datapath of the FNV-1a de-duplication counter: running hash and length, the
// hash-set memory, probe registers, saturating totals and the output register.
// Depends on fnvdd_pkg; driven by fnvdd_ctrl.
module fnvdd_dp import fnvdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fnvdd_cmd_t  cmd_i,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  input  logic        out_ready_i,
  output fnvdd_stat_t stat_o,
  output logic        out_valid_o,
  output logic [31:0] file_hash_o,
  output logic        is_duplicate_o,
  output logic        table_full_o,
  output logic [31:0] files_seen_o,
  output logic [31:0] duplicates_seen_o,
  output logic [31:0] unique_seen_o,
  output logic [47:0] bytes_total_o,
  output logic [47:0] bytes_unique_o
);

  logic [SlotW-1:0] mem [TableDepth];
  logic [SlotW-1:0] rd_q;

  logic [31:0]     running_hash_q;
  logic [47:0]     file_length_q;
  logic [IdxW-1:0] clear_idx_q;
  logic [31:0]     files_q, dups_q, uniq_q;
  logic [47:0]     total_q, ubytes_q;
  logic            out_valid_q;

  logic [31:0]     probe_hash_q;
  logic [47:0]     probe_len_q;
  logic [IdxW-1:0] probe_idx_q;
  logic [IdxW-1:0] probe_cnt_q;
  logic            dup_q, full_q;
  logic [31:0]     out_hash_q;
  logic            out_dup_q, out_full_q;

  logic [31:0]     hash_mix;
  logic [31:0]     hash_next;
  logic [47:0]     len_next;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [SlotW-1:0] mem_wdata;

  assign hash_mix  = running_hash_q ^ {24'd0, byte_value_i};
  assign hash_next = 32'(hash_mix * FnvPrime);
  assign len_next  = (file_length_q == Max48) ? file_length_q : file_length_q + 48'd1;

  assign mem_we    = cmd_i.clear_step | cmd_i.insert;
  assign mem_waddr = cmd_i.clear_step ? clear_idx_q : probe_idx_q;
  assign mem_wdata = cmd_i.clear_step ? '0 : {1'b1, probe_hash_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.mem_read) rd_q <= mem[probe_idx_q];
  end

  assign stat_o.clear_last = (clear_idx_q == IdxW'(TableDepth - 1));
  assign stat_o.slot_used  = rd_q[SlotW-1];
  assign stat_o.slot_match = (rd_q[31:0] == probe_hash_q);
  assign stat_o.probe_last = (probe_cnt_q == IdxW'(TableDepth - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Control state and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_hash_q <= FnvBasis;
      file_length_q  <= '0;
      clear_idx_q    <= '0;
      files_q        <= '0;
      dups_q         <= '0;
      uniq_q         <= '0;
      total_q        <= '0;
      ubytes_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clear_idx_q <= clear_idx_q + IdxW'(1);
      if (cmd_i.take) begin
        if (last_byte_i) begin
          running_hash_q <= FnvBasis;
          file_length_q  <= '0;
        end else begin
          running_hash_q <= hash_next;
          file_length_q  <= len_next;
        end
      end
      if (cmd_i.emit) begin
        files_q <= sat_inc32(files_q);
        total_q <= sat_add48(total_q, probe_len_q);
        if (dup_q) begin
          dups_q <= sat_inc32(dups_q);
        end else begin
          uniq_q   <= sat_inc32(uniq_q);
          ubytes_q <= sat_add48(ubytes_q, probe_len_q);
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Probe and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && last_byte_i) begin
      probe_hash_q <= hash_next;
      probe_len_q  <= len_next;
      probe_idx_q  <= hash_next[IdxW-1:0];
      probe_cnt_q  <= '0;
    end
    if (cmd_i.advance) begin
      probe_idx_q <= probe_idx_q + IdxW'(1);
      probe_cnt_q <= probe_cnt_q + IdxW'(1);
    end
    if (cmd_i.insert) begin
      dup_q  <= 1'b0;
      full_q <= 1'b0;
    end
    if (cmd_i.mark_dup) begin
      dup_q  <= 1'b1;
      full_q <= 1'b0;
    end
    if (cmd_i.mark_full) begin
      dup_q  <= 1'b0;
      full_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_hash_q <= probe_hash_q;
      out_dup_q  <= dup_q;
      out_full_q <= full_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign file_hash_o       = out_hash_q;
  assign is_duplicate_o    = out_dup_q;
  assign table_full_o      = out_full_q;
  // Totals change only at a new result, which waits until the current one is taken.
  assign files_seen_o      = files_q;
  assign duplicates_seen_o = dups_q;
  assign unique_seen_o     = uniq_q;
  assign bytes_total_o     = total_q;
  assign bytes_unique_o    = ubytes_q;

endmodule
